FILE: sv/rar_pkg.sv
// shared types, constants and microprogram rom for the rational accumulator
// no dependencies; used by rar_seq and rational_accumulator_reduce_unit
package rar_pkg;

	// word width that a reduced sum must fit
	localparam int WORD_BITS = 32;
	localparam logic [63:0] HALF = 64'(1) << (WORD_BITS - 1);

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// microprogram step addresses
	localparam int STEP_BITS = 4;
	typedef logic [STEP_BITS-1:0] step_t;
	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_CHECK    = 4'd1;
	localparam step_t STEP_MUL_AD   = 4'd2;
	localparam step_t STEP_MUL_DB   = 4'd3;
	localparam step_t STEP_GCD_LOAD = 4'd4;
	localparam step_t STEP_GCD      = 4'd5;
	localparam step_t STEP_DIVN_LD  = 4'd6;
	localparam step_t STEP_DIVN     = 4'd7;
	localparam step_t STEP_DIVD_LD  = 4'd8;
	localparam step_t STEP_DIVD     = 4'd9;
	localparam step_t STEP_COMMIT   = 4'd10;
	localparam step_t STEP_ZERO     = 4'd11;
	localparam step_t STEP_REJ_DEN  = 4'd12;
	localparam step_t STEP_SPARE0   = 4'd13;
	localparam step_t STEP_SPARE1   = 4'd14;
	localparam step_t STEP_OUT      = 4'd15;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_MUL_NB,
		OP_MUL_AD,
		OP_MUL_DB,
		OP_GCD_LOAD,
		OP_GCD_STEP,
		OP_DIVN_LOAD,
		OP_DIV_STEP,
		OP_DIVD_LOAD,
		OP_COMMIT,
		OP_ZERO,
		OP_REJ_DEN,
		OP_SHOW
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_DEN_ZERO,
		C_NUM_ZERO,
		C_GCD_MORE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	// one control word
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// status flags from datapath to sequencer
	typedef struct packed {
		logic no_input;
		logic den_zero;
		logic num_zero;
		logic gcd_more;
		logic div_more;
		logic out_busy;
	} flags_t;

	// microprogram: jump to target when cond holds, else next step
	function automatic ucode_t rom_word(step_t step);
		ucode_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE:     w = '{op: OP_CAPTURE,   cond: C_NO_INPUT, target: STEP_IDLE};
			STEP_CHECK:    w = '{op: OP_MUL_NB,    cond: C_DEN_ZERO, target: STEP_REJ_DEN};
			STEP_MUL_AD:   w = '{op: OP_MUL_AD,    cond: C_NEVER,    target: STEP_IDLE};
			STEP_MUL_DB:   w = '{op: OP_MUL_DB,    cond: C_NEVER,    target: STEP_IDLE};
			STEP_GCD_LOAD: w = '{op: OP_GCD_LOAD,  cond: C_NUM_ZERO, target: STEP_ZERO};
			STEP_GCD:      w = '{op: OP_GCD_STEP,  cond: C_GCD_MORE, target: STEP_GCD};
			STEP_DIVN_LD:  w = '{op: OP_DIVN_LOAD, cond: C_NEVER,    target: STEP_IDLE};
			STEP_DIVN:     w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: STEP_DIVN};
			STEP_DIVD_LD:  w = '{op: OP_DIVD_LOAD, cond: C_NEVER,    target: STEP_IDLE};
			STEP_DIVD:     w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: STEP_DIVD};
			STEP_COMMIT:   w = '{op: OP_COMMIT,    cond: C_ALWAYS,   target: STEP_OUT};
			STEP_ZERO:     w = '{op: OP_ZERO,      cond: C_ALWAYS,   target: STEP_OUT};
			STEP_REJ_DEN:  w = '{op: OP_REJ_DEN,   cond: C_ALWAYS,   target: STEP_OUT};
			STEP_OUT:      w = '{op: OP_SHOW,      cond: C_OUT_BUSY, target: STEP_OUT};
			default:       w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/rar_seq.sv
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on rar_pkg
module rar_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  rar_pkg::flags_t flags,
	output rar_pkg::op_t    op
);
	import rar_pkg::*;

	step_t  upc_q;
	step_t  upc_next;
	ucode_t uword;
	logic   take;

	// control word of the current step
	always_comb begin
		uword = rom_word(upc_q);
	end

	// condition select
	always_comb begin
		unique case (uword.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_INPUT: take = flags.no_input;
			C_DEN_ZERO: take = flags.den_zero;
			C_NUM_ZERO: take = flags.num_zero;
			C_GCD_MORE: take = flags.gcd_more;
			C_DIV_MORE: take = flags.div_more;
			C_OUT_BUSY: take = flags.out_busy;
			default:    take = 1'b1;
		endcase
	end

	// next step: jump target or fall through (last step wraps to idle)
	always_comb begin
		upc_next = take ? uword.target : upc_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	assign op = uword.op;

endmodule

FILE: sv/rational_accumulator_reduce_unit.sv
// top level of the rational accumulator: stream ports and arithmetic datapath
// depends on rar_pkg and rar_seq
//
// Keeps a running fraction, 0/1 after reset, and adds each incoming fraction
// to it, reducing the sum to lowest terms with a positive denominator. One
// result transaction follows every input transaction: the running sum and a
// status (0 ok, 1 zero denominator rejected, 2 result too wide rejected; on
// rejection the sum is unchanged). Items are handled one at a time by a
// microcoded datapath with one shared 33x33 multiplier, a binary gcd loop
// that does one shift or one subtract per cycle, and a radix-2 divider run
// twice, once for the numerator and once for the denominator. The gcd loop
// works on 64-bit intermediates; a zero sum or a zero denominator skips the
// gcd loop and the divider. The next item is taken while the previous
// result waits at the output register.
module rational_accumulator_reduce_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] addend_num, [62:32] addend_den
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] sum_num, [62:32] sum_den
	output logic [1:0]  m_tuser    // [1:0] status
);
	import rar_pkg::*;

	op_t    op;
	flags_t flags;

	// running sum
	logic signed [31:0] acc_num_q;
	logic        [30:0] acc_den_q;

	// item and working registers
	logic signed [31:0] a_q;
	logic        [30:0] b_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] num_q;
	logic        [63:0] x_q;
	logic        [63:0] y_q;
	logic        [63:0] mag_q;
	logic        [63:0] den_q;
	logic               neg_q;
	logic        [63:0] rem_q;
	logic        [63:0] quo_q;
	logic        [63:0] dvs_q;
	logic        [5:0]  cnt_q;
	logic        [1:0]  status_q;

	// output register
	logic               out_valid_q;
	logic        [31:0] out_num_q;
	logic        [30:0] out_den_q;
	logic        [1:0]  out_status_q;

	logic signed [32:0] mul_x;
	logic signed [32:0] mul_y;
	logic signed [65:0] mul_p;
	logic        [63:0] num_abs;
	logic        [64:0] div_shl;
	logic               div_ge;
	logic        [64:0] div_dif;
	logic               overflow;
	logic               out_busy;

	rar_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	// shared multiplier operand select
	always_comb begin
		unique case (op)
			OP_MUL_NB: begin
				mul_x = {acc_num_q[31], acc_num_q};
				mul_y = {2'b00, b_q};
			end
			OP_MUL_AD: begin
				mul_x = {a_q[31], a_q};
				mul_y = {2'b00, acc_den_q};
			end
			default: begin
				mul_x = {2'b00, acc_den_q};
				mul_y = {2'b00, b_q};
			end
		endcase
		mul_p = mul_x * mul_y;
	end

	// magnitude of the sum
	assign num_abs = num_q[63] ? 64'(-num_q) : 64'(num_q);

	// one restoring division step
	assign div_shl = {rem_q, quo_q[63]};
	assign div_ge  = div_shl >= {1'b0, dvs_q};
	assign div_dif = div_shl - {1'b0, dvs_q};

	// range check of the reduced sum (quotient holds the reduced denominator)
	assign overflow = (neg_q ? (mag_q > HALF) : (mag_q > HALF - 64'(1)))
		|| (quo_q > HALF - 64'(1));

	assign out_busy = out_valid_q && !m_tready;

	// flags for the sequencer
	always_comb begin
		flags.no_input = !s_tvalid;
		flags.den_zero = (b_q == '0);
		flags.num_zero = (num_q == '0);
		flags.gcd_more = (x_q != '0) && (y_q != '0);
		flags.div_more = (cnt_q != '1);
		flags.out_busy = out_busy;
	end

	// running sum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q   <= '0;
			acc_den_q   <= 31'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_ZERO) begin
				acc_num_q <= '0;
				acc_den_q <= 31'd1;
			end else if (op == OP_COMMIT && !overflow) begin
				acc_num_q <= neg_q ? 32'(-mag_q) : mag_q[31:0];
				acc_den_q <= quo_q[30:0];
			end
			if (op == OP_SHOW && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		unique case (op)
			OP_CAPTURE: begin
				a_q <= s_tdata[31:0];
				b_q <= s_tdata[62:32];
			end
			OP_MUL_NB: begin
				prod_q <= mul_p[63:0];
			end
			OP_MUL_AD: begin
				num_q  <= prod_q;
				prod_q <= mul_p[63:0];
			end
			OP_MUL_DB: begin
				num_q  <= num_q + prod_q;
				prod_q <= mul_p[63:0];
			end
			OP_GCD_LOAD: begin
				x_q   <= num_abs;
				y_q   <= prod_q;
				mag_q <= num_abs;
				den_q <= prod_q;
				neg_q <= num_q[63];
			end
			OP_GCD_STEP: begin
				// common factors of two come off the sum too
				if (x_q != '0 && y_q != '0) begin
					if (!x_q[0] && !y_q[0]) begin
						x_q   <= x_q >> 1;
						y_q   <= y_q >> 1;
						mag_q <= mag_q >> 1;
						den_q <= den_q >> 1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q >= y_q) begin
						x_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
			end
			OP_DIVN_LOAD: begin
				rem_q <= '0;
				quo_q <= mag_q;
				dvs_q <= x_q | y_q;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? div_dif[63:0] : div_shl[63:0];
				quo_q <= {quo_q[62:0], div_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			OP_DIVD_LOAD: begin
				mag_q <= quo_q;
				rem_q <= '0;
				quo_q <= den_q;
				cnt_q <= '0;
			end
			OP_COMMIT: begin
				status_q <= overflow ? ST_OVERFLOW : ST_OK;
			end
			OP_ZERO: begin
				status_q <= ST_OK;
			end
			OP_REJ_DEN: begin
				status_q <= ST_ZERO_DEN;
			end
			OP_SHOW: begin
				if (!out_busy) begin
					out_num_q    <= acc_num_q;
					out_den_q    <= acc_den_q;
					out_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// stream ports
	assign s_tready = (op == OP_CAPTURE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_den_q, out_num_q};
	assign m_tuser  = out_status_q;

endmodule

FILE: test/rational_accumulator_reduce_unit_test.sv
// testbench for rational_accumulator_reduce_unit: directed and random fraction adds
// depends on rar_pkg and the unit under test; predicts every running sum itself
`timescale 1ns / 1ps

module rational_accumulator_reduce_unit_test;
	import rar_pkg::*;

	localparam int IDLE_LIMIT   = 20000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_ITEMS = 480;

	// one running sum transaction as seen at the output
	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic [1:0]         status;
	} sum_result_t;

	// running fraction predictor and queue of expected sums
	class fraction_scoreboard;
		longint          sum_num;
		longint unsigned sum_den;
		sum_result_t     expected_sums[$];
		int              errors;
		int              checked;
		int              zero_den_count;
		int              overflow_count;
		int              zero_sum_count;

		function new();
			sum_num = 0;
			sum_den = 1;
		endfunction

		// add one accepted fraction to the running sum and queue the result
		function void note_addend(logic signed [31:0] a, logic [30:0] b);
			longint          num;
			longint unsigned den, mag, x, y, t;
			bit              neg;
			sum_result_t     r;
			r.status = ST_OK;
			if (b == 0) begin
				r.status = ST_ZERO_DEN;
				zero_den_count++;
			end else begin
				num = sum_num * longint'(b) + longint'(a) * longint'(sum_den);
				den = sum_den * longint'(b);
				if (num == 0) begin
					sum_num = 0;
					sum_den = 1;
					zero_sum_count++;
				end else begin
					neg = num < 0;
					mag = neg ? -num : num;
					// euclid on the unreduced magnitude and denominator
					x = mag;
					y = den;
					while (y != 0) begin
						t = x % y;
						x = y;
						y = t;
					end
					mag = mag / x;
					den = den / x;
					if ((neg ? mag > HALF : mag > HALF - 1) || den > HALF - 1) begin
						r.status = ST_OVERFLOW;
						overflow_count++;
					end else begin
						sum_num = neg ? -longint'(mag) : longint'(mag);
						sum_den = den;
					end
				end
			end
			r.num = sum_num[31:0];
			r.den = sum_den[30:0];
			expected_sums.push_back(r);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		// compare one output transaction with the oldest expected sum
		task check_sum(logic signed [31:0] num, logic [30:0] den, logic [1:0] status);
			sum_result_t want;
			if (expected_sums.size() == 0) begin
				report_mismatch("unexpected result, numerator", num, 0);
			end else begin
				want = expected_sums.pop_front();
				checked++;
				if (num !== want.num)
					report_mismatch("sum_num", num, want.num);
				if (den !== want.den)
					report_mismatch("sum_den", den, want.den);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;      // [31:0] addend_num, [62:32] addend_den
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // [31:0] sum_num, [62:32] sum_den
	logic [1:0]  m_tuser;           // [1:0] status

	fraction_scoreboard sums = new();
	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int fractions_sent = 0;
	int idle_cycles = 0;

	rational_accumulator_reduce_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// offer one fraction and hold it until the transaction completes
	task automatic send_fraction(input logic signed [31:0] num, input logic [30:0] den);
		s_tdata <= {1'b0, den, num};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sums.note_addend(num, den);
		fractions_sent++;
	endtask

	// occasional gap on the input side, with junk on the data lines
	task automatic maybe_idle();
		int gap;
		if (!steady && $urandom_range(99) < 6) begin
			gap = $urandom_range(1, 20);
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom};
			repeat (gap) @(posedge clk);
		end
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= steady || $urandom_range(99) >= 6;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sums.check_sum($signed(m_tdata[31:0]), m_tdata[62:32], m_tuser);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TIMEOUT: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic signed [31:0] num;
		logic [30:0]        den;
		int                 pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero denominators, extremes, cancellation, overflow
		send_fraction(32'sd0, 31'd0);
		send_fraction(32'sd1, 31'd2);
		send_fraction(32'sd1, 31'd3);
		send_fraction(-32'sd5, 31'd6);
		send_fraction(32'sd7, 31'd1);
		send_fraction(32'sh7FFFFFFF, 31'h7FFFFFFF);
		send_fraction(32'sh80000000, 31'd1);
		send_fraction(-32'sd8, 31'd1);
		send_fraction(-32'sd1, 31'd1);
		send_fraction(32'sh7FFFFFFF, 31'd1);
		send_fraction(32'sd1, 31'h7FFFFFFF);
		send_fraction(32'sd1, 31'd2);
		send_fraction(32'sh7FFFFFFE, 31'h7FFFFFFF);
		send_fraction(32'sh80000000, 31'd0);
		send_fraction(32'sd6, 31'd4);
		send_fraction(-32'sd3, 31'd2);
		send_fraction(32'sd1, 31'd1000000);
		send_fraction(32'sd1, 31'd999999);
		send_fraction(32'sd0, 31'd5);
		send_fraction(-32'sd1, 31'd1000000);
		send_fraction(32'sh7FFFFFFF, 31'h7FFFFFFE);
		send_fraction(32'sh80000000, 31'h7FFFFFFF);
		send_fraction(32'shFFFFFFFF, 31'h40000000);

		// random: mostly small fractions that stay in range, plus cancellation and noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 60 && i < 160);
			if (i == 250)
				hold_request = 1'b1;
			if (i == 350) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sums.expected_sums.size() != 0);
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				num = $urandom;
				den = '0;
			end else if (pick < 18) begin
				num = $urandom;
				den = 31'($urandom_range(1, 32'h7FFFFFFF));
			end else if (pick < 28 && sums.sum_num != -longint'(HALF)) begin
				num = 32'(-sums.sum_num);
				den = 31'(sums.sum_den);
			end else if (pick < 40) begin
				num = $signed($urandom_range(2000)) - 1000;
				den = 31'd1;
			end else begin
				num = $signed($urandom_range(2000)) - 1000;
				if ($urandom_range(1))
					den = 31'd1 << $urandom_range(6);
				else
					den = 31'($urandom_range(1, 1000));
			end
			send_fraction(num, den);
			maybe_idle();
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		// drain and settle
		while (sums.expected_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d fractions added, %0d sums checked, %0d mismatches", fractions_sent,
			sums.checked, sums.errors);
		$display("rejections: %0d zero denominator, %0d too wide; %0d sums back to zero",
			sums.zero_den_count, sums.overflow_count, sums.zero_sum_count);
		if (sums.errors == 0 && sums.expected_sums.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
